[rtl/nmsc_pkg.sv]
// Shared types, constants and helpers for the NMEA sentence checker.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package nmsc_pkg;

  // Line buffer capacity and the position limit for finding the star.
  localparam int unsigned LINE_CAPACITY = 128;
  localparam int unsigned SCAN_LIMIT    = 75;

  localparam int unsigned COUNT_W  = $clog2(LINE_CAPACITY);
  localparam int unsigned LENGTH_W = 7;
  localparam int unsigned PREFIX_LEN = 6;
  localparam int unsigned NUM_KINDS  = 3;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // Sentence kind codes.
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_GGA   = 2'd1;
  localparam logic [1:0] KIND_GLL   = 2'd2;
  localparam logic [1:0] KIND_RMC   = 2'd3;

  // Sentence prefixes, one row per kind in the order GGA, GLL, RMC.
  localparam logic [7:0] PREFIX [NUM_KINDS][PREFIX_LEN] = '{
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C},
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43}
  };

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SUM   = 2'd1,
    PH_CHECK = 2'd2,
    PH_FAIL  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                sentence_valid;
    logic [1:0]          sentence_kind;
    logic [LENGTH_W-1:0] line_length;
    logic [7:0]          computed_checksum;
  } result_t;

  // Uppercase ASCII hex digit of the low nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
    logic [7:0] d;
    if (nibble < 4'd10) begin
      d = 8'h30 + {4'd0, nibble};
    end else begin
      d = 8'h37 + {4'd0, nibble};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/nmsc_frame.sv]
// Per-line state of the NMEA sentence checker: framing, XOR sum, star and
// check-digit capture, prefix match. Uses nmsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmsc_frame (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  output logic                  line_end,
  output nmsc_pkg::result_t     result
);

  logic [nmsc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  nmsc_pkg::phase_t             phase_r, phase_nxt;
  logic [1:0]                   digits_r, digits_nxt;
  logic [7:0]                   first_r, first_nxt;
  logic [7:0]                   second_r, second_nxt;
  logic [nmsc_pkg::NUM_KINDS-1:0] match_r, match_nxt;

  logic in_prefix;
  logic past_limit;

  assign in_prefix  = 32'(count_r) < nmsc_pkg::PREFIX_LEN;
  assign past_limit = 32'(count_r) >= nmsc_pkg::SCAN_LIMIT;
  assign line_end   = (rx_byte == nmsc_pkg::CHAR_NEWLINE) ||
                      (32'(count_r) >= nmsc_pkg::LINE_CAPACITY - 1);

  // Phase transitions.
  always_comb begin
    phase_nxt = phase_r;
    if (line_end) begin
      phase_nxt = nmsc_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        nmsc_pkg::PH_IDLE: begin
          phase_nxt = (rx_byte == nmsc_pkg::CHAR_DOLLAR) ? nmsc_pkg::PH_SUM
                                                         : nmsc_pkg::PH_FAIL;
        end
        nmsc_pkg::PH_SUM: begin
          if (past_limit || rx_byte == nmsc_pkg::CHAR_NUL) begin
            phase_nxt = nmsc_pkg::PH_FAIL;
          end else if (rx_byte == nmsc_pkg::CHAR_STAR) begin
            phase_nxt = nmsc_pkg::PH_CHECK;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Data state of the line.
  always_comb begin
    count_nxt  = count_r;
    xor_nxt    = xor_r;
    digits_nxt = digits_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    match_nxt  = match_r;
    if (line_end) begin
      count_nxt  = '0;
      xor_nxt    = '0;
      digits_nxt = '0;
      first_nxt  = '0;
      second_nxt = '0;
      match_nxt  = '1;
    end else begin
      count_nxt = count_r + 1'b1;
      if (in_prefix) begin
        for (int k = 0; k < nmsc_pkg::NUM_KINDS; k++) begin
          if (nmsc_pkg::PREFIX[k][count_r[2:0]] != rx_byte) begin
            match_nxt[k] = 1'b0;
          end
        end
      end
      if (phase_r == nmsc_pkg::PH_SUM && !past_limit &&
          rx_byte != nmsc_pkg::CHAR_NUL && rx_byte != nmsc_pkg::CHAR_STAR) begin
        xor_nxt = xor_r ^ rx_byte;
      end
      if (phase_r == nmsc_pkg::PH_CHECK) begin
        if (digits_r == 2'd0) begin
          first_nxt = rx_byte;
        end else if (digits_r == 2'd1) begin
          second_nxt = rx_byte;
        end
        if (digits_r < 2'd2) begin
          digits_nxt = digits_r + 2'd1;
        end
      end
    end
  end

  // Result of the line that ends on this beat.
  always_comb begin
    result.sentence_kind = nmsc_pkg::KIND_OTHER;
    if (!in_prefix) begin
      if (match_r[0]) begin
        result.sentence_kind = nmsc_pkg::KIND_GGA;
      end else if (match_r[1]) begin
        result.sentence_kind = nmsc_pkg::KIND_GLL;
      end else if (match_r[2]) begin
        result.sentence_kind = nmsc_pkg::KIND_RMC;
      end
    end
    result.sentence_valid = (phase_r == nmsc_pkg::PH_CHECK) &&
                            (first_r == nmsc_pkg::hex_digit(xor_r[7:4])) &&
                            (second_r == nmsc_pkg::hex_digit(xor_r[3:0]));
    result.line_length       = nmsc_pkg::LENGTH_W'(count_r);
    result.computed_checksum = xor_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      xor_r    <= '0;
      phase_r  <= nmsc_pkg::PH_IDLE;
      digits_r <= '0;
      first_r  <= '0;
      second_r <= '0;
      match_r  <= '1;
    end else if (step) begin
      count_r  <= count_nxt;
      xor_r    <= xor_nxt;
      phase_r  <= phase_nxt;
      digits_r <= digits_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      match_r  <= match_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/nmea_sentence_checker.sv]
// NMEA sentence checker: one received byte per beat in, one result per line.
// A line's ending byte passes through the input register; the line's result
// is then captured in the output register and held there until taken.
// Throughput: one byte per cycle; only the output register stalls the input.
// Reset (rst_n low, synchronous) empties both registers and starts a new line.
// Depends on nmsc_pkg and nmsc_frame.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_sentence_valid,
  output logic [1:0]      out_sentence_kind,
  output logic [6:0]      out_line_length,
  output logic [7:0]      out_computed_checksum
);

  // Input register: holds one accepted beat until the line logic takes it.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;

  // Output register: the last finished line result, held until taken.
  logic              out_vld_r, out_vld_nxt;
  nmsc_pkg::result_t res_r;

  logic              line_end;
  logic              advance;
  nmsc_pkg::result_t result;

  // A byte that ends no line always moves on; a line end needs room in the
  // output register, which frees up in the same cycle as it is taken.
  assign advance  = in_vld_r && (!line_end || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  assign in_vld_nxt  = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = (advance && line_end) ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  nmsc_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .rx_byte  (byte_r),
    .line_end (line_end),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
    if (advance && line_end) begin
      res_r <= result;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_sentence_valid    = res_r.sentence_valid;
  assign out_sentence_kind     = res_r.sentence_kind;
  assign out_line_length       = res_r.line_length;
  assign out_computed_checksum = res_r.computed_checksum;

endmodule

`default_nettype wire
